// ===== design/smes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smes_pkg: shared types and codes of the sparse matrix entry store
// Request layout, result layout, status codes, register indexes and the
// sequencer states of the back end.
// ----------------------------------------------------------------------------
package smes_pkg;

	localparam int unsigned ROW_W = 10;
	localparam int unsigned COL_W = 10;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned DIM_W = 11;

	// request opcodes
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// configuration register indexes
	localparam logic REG_NUM_ROWS = 1'b0;
	localparam logic REG_NUM_COLS = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_COMMIT
	} state_t;

	// classified request handed from front to back
	typedef struct packed {
		logic                    op;
		logic [ROW_W-1:0]        row;
		logic [COL_W-1:0]        col;
		logic signed [VAL_W-1:0] nv;
		logic                    range_err;
	} cmd_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		status_t                 status;
	} res_t;

endpackage

// ===== design/sparse_matrix_entry_store_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_matrix_entry_store_top: bounded store of sparse matrix entries
// Reads, updates, inserts and deletes nonzero entries keyed by row and
// column, with a range check against the programmed matrix size.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  request   push / full      cmd, row, col, new_value
//  result    pop / empty      value, status
//  config    cfg_we           cfg_idx, cfg_wdata
//
//  A request leaves the request queue, then its scan reads one slot per cycle
//  through the single read port of the entry memory, which has a registered
//  read, and then it commits once the result queue has room. A match ends the
//  scan early; an out-of-range request skips the scan. After reset a clearing
//  pass over every slot runs, and full stays high until it ends. Two requests
//  and two results can wait on either side, so each side stalls on its own.
// ----------------------------------------------------------------------------
module sparse_matrix_entry_store_top #(
	parameter int unsigned CAPACITY = 64,
	parameter int unsigned MAX_DIM  = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              cmd,
	input  logic [smes_pkg::ROW_W-1:0]        row,
	input  logic [smes_pkg::COL_W-1:0]        col,
	input  logic signed [smes_pkg::VAL_W-1:0] new_value,
	output logic                              empty,
	input  logic                              pop,
	output logic signed [smes_pkg::VAL_W-1:0] value,
	output logic [1:0]                        status,
	input  logic                              cfg_we,
	input  logic                              cfg_idx,
	input  logic [smes_pkg::DIM_W-1:0]        cfg_wdata
);
	import smes_pkg::*;

	logic cq_valid;
	cmd_t cq_head;
	logic cq_take;
	res_t res_head;
	logic clearing;

	// intake, classification and request queue
	smes_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.row       (row),
		.col       (col),
		.new_value (new_value),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.clearing  (clearing),
		.cq_valid  (cq_valid),
		.cq_head   (cq_head),
		.cq_take   (cq_take)
	);

	// entry store, scan and result queue
	smes_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cq_valid  (cq_valid),
		.cq_head   (cq_head),
		.cq_take   (cq_take),
		.res_empty (empty),
		.res_pop   (pop),
		.res_head  (res_head),
		.clearing  (clearing)
	);

	assign value  = res_head.value;
	assign status = res_head.status;

endmodule

// ===== design/smes_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smes_front: request intake and classification
// Holds the size registers, checks each request against the live matrix
// size and parks it in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module smes_front #(
	parameter int unsigned MAX_DIM = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic                                cmd,
	input  logic [smes_pkg::ROW_W-1:0]          row,
	input  logic [smes_pkg::COL_W-1:0]          col,
	input  logic signed [smes_pkg::VAL_W-1:0]   new_value,
	input  logic                                cfg_we,
	input  logic                                cfg_idx,
	input  logic [smes_pkg::DIM_W-1:0]          cfg_wdata,
	input  logic                                clearing,
	output logic                                cq_valid,
	output smes_pkg::cmd_t                      cq_head,
	input  logic                                cq_take
);
	import smes_pkg::*;

	localparam int unsigned LW = $clog2(MAX_DIM + 1);
	localparam int unsigned CW = (LW > DIM_W) ? LW : DIM_W;

	logic [DIM_W-1:0] num_rows_q;
	logic [DIM_W-1:0] num_cols_q;
	logic [CW-1:0]    lim_row;
	logic [CW-1:0]    lim_col;
	logic             accept;
	cmd_t             req;
	cmd_t             cq_mem_q [2];
	logic             cq_wp_q;
	logic             cq_rp_q;
	logic [1:0]       cq_cnt_q;

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= DIM_W'(1024);
			num_cols_q <= DIM_W'(1024);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_NUM_ROWS: num_rows_q <= cfg_wdata;
				REG_NUM_COLS: num_cols_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// effective limits, clipped to the built matrix size
	always_comb begin
		lim_row = (CW'(num_rows_q) < CW'(MAX_DIM)) ? CW'(num_rows_q) : CW'(MAX_DIM);
		lim_col = (CW'(num_cols_q) < CW'(MAX_DIM)) ? CW'(num_cols_q) : CW'(MAX_DIM);
	end

	// classify the incoming request
	always_comb begin
		req.op        = cmd;
		req.row       = row;
		req.col       = col;
		req.nv        = new_value;
		req.range_err = (CW'(row) >= lim_row) || (CW'(col) >= lim_col);
	end

	// no requests while the store is being cleared
	assign full     = (cq_cnt_q == 2'd2) || clearing;
	assign accept   = push && !full;
	assign cq_valid = (cq_cnt_q != 2'd0);
	assign cq_head  = cq_mem_q[cq_rp_q];

	// request queue storage
	always_ff @(posedge clk) begin
		if (accept) begin
			cq_mem_q[cq_wp_q] <= req;
		end
	end

	// request queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cq_wp_q  <= 1'b0;
			cq_rp_q  <= 1'b0;
			cq_cnt_q <= 2'd0;
		end else begin
			if (accept) begin
				cq_wp_q <= ~cq_wp_q;
			end
			if (cq_take) begin
				cq_rp_q <= ~cq_rp_q;
			end
			cq_cnt_q <= cq_cnt_q + 2'(accept) - 2'(cq_take);
		end
	end

endmodule

// ===== design/smes_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smes_back: entry store and scan sequencer
// Clears the entry memory after reset, then serves one request at a time by
// scanning the slots for a match and the lowest free slot, commits the
// update and queues the result.
// ----------------------------------------------------------------------------
module smes_back #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cq_valid,
	input  smes_pkg::cmd_t cq_head,
	output logic           cq_take,
	output logic           res_empty,
	input  logic           res_pop,
	output smes_pkg::res_t res_head,
	output logic           clearing
);
	import smes_pkg::*;

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
	localparam logic [AW:0]   CAP_CNT  = (AW + 1)'(CAPACITY);

	typedef struct packed {
		logic                    vld;
		logic [ROW_W-1:0]        row;
		logic [COL_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
	} entry_t;

	entry_t                  mem [CAPACITY];
	entry_t                  rdata_s1;
	logic                    look_s1;
	logic [AW-1:0]           lidx_s1;
	state_t                  state_q;
	state_t                  state_d;
	logic [AW:0]             idx_q;
	logic [AW-1:0]           clr_q;
	cmd_t                    cur_q;
	logic                    hit_q;
	logic [AW-1:0]           hit_idx_q;
	logic signed [VAL_W-1:0] old_q;
	logic                    free_q;
	logic [AW-1:0]           free_idx_q;
	res_t                    rq_mem_q [2];
	logic                    rq_wp_q;
	logic                    rq_rp_q;
	logic [1:0]              rq_cnt_q;

	logic                    look_hit;
	logic                    look_free;
	logic                    scan_done;
	logic                    rq_full;
	logic                    rq_pop;
	logic                    rd_en;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	entry_t                  wr_data;
	logic                    rq_push;
	res_t                    res_d;

	// compare the slot read last cycle against the current request
	always_comb begin
		look_hit  = look_s1 && rdata_s1.vld && (rdata_s1.row == cur_q.row)
			&& (rdata_s1.col == cur_q.col);
		look_free = look_s1 && !rdata_s1.vld;
		scan_done = look_hit || (look_s1 && (lidx_s1 == LAST_IDX));
		rq_full   = (rq_cnt_q == 2'd2);
		rq_pop    = res_pop && (rq_cnt_q != 2'd0);
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == LAST_IDX) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (cq_valid) begin
					state_d = cq_head.range_err ? S_COMMIT : S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (!rq_full) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		cq_take      = 1'b0;
		rd_en        = 1'b0;
		wr_en        = 1'b0;
		wr_addr      = '0;
		wr_data      = '0;
		rq_push      = 1'b0;
		res_d.value  = '0;
		res_d.status = ST_OK;
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			S_IDLE: begin
				cq_take = cq_valid;
			end
			S_SCAN: begin
				rd_en = (idx_q < CAP_CNT) && !scan_done;
			end
			S_COMMIT: begin
				if (!rq_full) begin
					rq_push = 1'b1;
					if (cur_q.range_err) begin
						res_d.status = ST_RANGE;
					end else begin
						res_d.value = hit_q ? old_q : '0;
						wr_data.vld   = (cur_q.nv != '0);
						wr_data.row   = cur_q.row;
						wr_data.col   = cur_q.col;
						wr_data.value = cur_q.nv;
						if (cur_q.op == CMD_WRITE) begin
							if (hit_q) begin
								// update, or delete on zero
								wr_en   = 1'b1;
								wr_addr = hit_idx_q;
							end else if (cur_q.nv != '0) begin
								if (free_q) begin
									wr_en   = 1'b1;
									wr_addr = free_idx_q;
								end else begin
									res_d.status = ST_FULL;
								end
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	// sequencer and scan control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			idx_q   <= '0;
			look_s1 <= 1'b0;
			lidx_s1 <= '0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			look_s1 <= rd_en;
			lidx_s1 <= idx_q[AW-1:0];
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cq_take) begin
				idx_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else begin
				if (rd_en) begin
					idx_q <= idx_q + 1'b1;
				end
				if (look_hit) begin
					hit_q <= 1'b1;
				end
				if (look_free) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	// scan payload: current request, matching slot, lowest free slot
	always_ff @(posedge clk) begin
		if (cq_take) begin
			cur_q <= cq_head;
		end
		if (look_hit) begin
			hit_idx_q <= lidx_s1;
			old_q     <= rdata_s1.value;
		end
		if (look_free && !free_q) begin
			free_idx_q <= lidx_s1;
		end
	end

	// entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[idx_q[AW-1:0]];
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (rq_push) begin
			rq_mem_q[rq_wp_q] <= res_d;
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wp_q  <= 1'b0;
			rq_rp_q  <= 1'b0;
			rq_cnt_q <= 2'd0;
		end else begin
			if (rq_push) begin
				rq_wp_q <= ~rq_wp_q;
			end
			if (rq_pop) begin
				rq_rp_q <= ~rq_rp_q;
			end
			rq_cnt_q <= rq_cnt_q + 2'(rq_push) - 2'(rq_pop);
		end
	end

	assign res_empty = (rq_cnt_q == 2'd0);
	assign res_head  = rq_mem_q[rq_rp_q];
	assign clearing  = (state_q == S_CLEAR);

`ifndef SYNTHESIS
	// no request is taken before the clearing pass is over
	a_no_take_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !cq_take)
		else $error("request taken during clearing pass");

	// a full status only when the scan found neither a match nor a free slot
	a_full_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rq_push && (res_d.status == ST_FULL)) |-> (!hit_q && !free_q))
		else $error("full status with a slot available");

	// scan reads stay inside the store
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (idx_q < CAP_CNT))
		else $error("scan read beyond capacity");

	// a committed slot write lands on the matched slot when there was a match
	a_hit_target: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && (state_q == S_COMMIT) && hit_q) |-> (wr_addr == hit_idx_q))
		else $error("update written to wrong slot");
`endif

endmodule
